/* hdl/bgl_pkg.sv */
package bgl_pkg;

   // Width of each operand and result field on the stream ports
   localparam int FIELD_WIDTH = 32;
   // Default working width of the operands (range 8 to 32)
   localparam int OPERAND_WIDTH_DEF = 32;
   // Width of the operation selector
   localparam int OP_WIDTH = 2;

   // Operation codes; code 3 is unused and returns zero
   typedef enum logic [OP_WIDTH-1:0] {
      OP_GCD  = 2'd0,
      OP_LCM  = 2'd1,
      OP_SLCM = 2'd2
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } state_type;

   // Status from the shared subtractor
   typedef struct packed {
      logic borrow;
      logic zero;
   } sub_flags_type;

endpackage

/* hdl/bgl_sub_unit.sv */
module bgl_sub_unit #(
   parameter int WIDTH = bgl_pkg::OPERAND_WIDTH_DEF + 1
) (
   input  logic [WIDTH-1:0]      minuend,
   input  logic [WIDTH-1:0]      subtrahend,
   output logic [WIDTH-1:0]      diff,
   output logic [WIDTH-1:0]      abs_diff,
   output bgl_pkg::sub_flags_type flags
);
   import bgl_pkg::*;

   logic [WIDTH:0] wide;

   // One subtract serves compare, difference and magnitude
   assign wide     = {1'b0, minuend} - {1'b0, subtrahend};
   assign diff     = wide[WIDTH-1:0];
   assign abs_diff = wide[WIDTH] ? (~wide[WIDTH-1:0] + WIDTH'(1)) : wide[WIDTH-1:0];

   always_comb begin
      flags.borrow = wide[WIDTH];
      flags.zero   = (wide == '0);
   end

endmodule

/* hdl/binary_gcd_lcm_unit_core.sv */
// Binary GCD / LCM unit.
// Request channel (req_*): tuser carries the operation (0 unsigned gcd,
// 1 unsigned lcm, 2 signed lcm), tdata carries operand_a in bits 31:0 and
// operand_b in bits 63:32. Only the low OPERAND_WIDTH bits of each are used.
// Response channel (rsp_*): tdata carries the result (low OPERAND_WIDTH bits,
// upper bits zero), tuser carries the overflow flag.
// One request is processed at a time; req_tready is high only while idle.
// Sequence: gcd takes a load step, shift-subtract steps and a finish step;
// lcm adds W restoring division steps and a multiply step. The gcd and
// division steps share a single (W+1)-bit subtractor; the multiply does not.
// Unused op code 3 goes from load straight to the finish step with result 0.
// The finished response sits in an output register; the next request is
// accepted while it waits. If the receiver stalls and the register is still
// full when the next result is ready, the sequencer holds in its final state.
// Synchronous reset returns to idle with no response pending.
module binary_gcd_lcm_unit_core #(
   parameter int OPERAND_WIDTH = bgl_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2*bgl_pkg::FIELD_WIDTH-1:0] req_tdata,  // operand_a, operand_b
   input  logic [bgl_pkg::OP_WIDTH-1:0]    req_tuser,   // op
   // response
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bgl_pkg::FIELD_WIDTH-1:0] rsp_tdata,   // result
   output logic                            rsp_tuser    // overflow
);
   import bgl_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic [W-1:0]      x_ff, x_in;
   logic [W-1:0]      y_ff, y_in;
   logic [W-1:0]      a_ff, a_in;
   logic [W-1:0]      b_ff, b_in;
   logic [W-1:0]      g_ff, g_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]  twos_ff, twos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2*W-1:0]    m_ff, m_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]      res_ff, res_in;
   logic              ovf_ff, ovf_in;

   logic              accept;
   logic              load_out;
   logic              gcd_done;
   logic [W-1:0]      req_a, req_b;
   logic              a_neg, b_neg;
   logic [W-1:0]      a_mag, b_mag;
   logic [W:0]        sub_a, sub_b, sub_diff, sub_abs;
   sub_flags_type     sub_flags;
   logic [W:0]        div_shift;
   logic [2*W-1:0]    product;
   logic [W-1:0]      gcd_sel;

   assign accept   = req_tvalid && req_tready;
   assign load_out = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   // Operand extraction and signed magnitudes
   assign req_a = req_tdata[W-1:0];
   assign req_b = req_tdata[FIELD_WIDTH+W-1:FIELD_WIDTH];
   assign a_neg = (op_type'(req_tuser) == OP_SLCM) && req_a[W-1];
   assign b_neg = (op_type'(req_tuser) == OP_SLCM) && req_b[W-1];
   assign a_mag = a_neg ? (~req_a + W'(1)) : req_a;
   assign b_mag = b_neg ? (~req_b + W'(1)) : req_b;

   // Shared subtractor: gcd compare/subtract or division trial subtract
   assign div_shift = {rem_ff, a_ff[W-1]};
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = div_shift;
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end
   end

   bgl_sub_unit #(
      .WIDTH (W + 1)
   ) u_sub (
      .minuend    (sub_a),
      .subtrahend (sub_b),
      .diff       (sub_diff),
      .abs_diff   (sub_abs),
      .flags      (sub_flags)
   );

   assign gcd_done = (x_ff == '0) || (y_ff == '0) || sub_flags.zero;
   assign gcd_sel  = (x_ff == '0) ? y_ff : x_ff;
   assign product  = (2*W)'(a_ff) * (2*W)'(b_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_GCD || req_tuser == OP_LCM || req_tuser == OP_SLCM)
                  state_in = ST_GCD;
               else
                  state_in = ST_FIN;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               if (op_ff == OP_GCD || zero_ff)
                  state_in = ST_FIN;
               else
                  state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(W - 1))
               state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (load_out)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      op_in   = op_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      g_in    = g_ff;
      rem_in  = rem_ff;
      twos_in = twos_ff;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = op_type'(req_tuser);
               neg_in  = b_neg ? (!a_neg && req_a != '0) : a_neg;
               zero_in = (req_a == '0) || (req_b == '0);
               x_in    = a_mag;
               y_in    = b_mag;
               a_in    = a_mag;
               b_in    = b_mag;
               g_in    = '0;
               twos_in = '0;
               m_in    = '0;
            end
         end
         ST_GCD: begin
            priority if (gcd_done) begin
               g_in   = gcd_sel << twos_ff;
               rem_in = '0;
               cnt_in = '0;
               m_in   = '0;
            end else if (!x_ff[0] && !y_ff[0]) begin
               twos_in = twos_ff + CNT_W'(1);
               x_in    = x_ff >> 1;
               y_in    = y_ff >> 1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else begin
               // both odd: larger becomes |x-y|/2, the smaller stays
               x_in = sub_abs[W:1];
               y_in = sub_flags.borrow ? x_ff : y_ff;
            end
         end
         ST_DIV: begin
            // restoring division step; quotient bits shift into a_ff
            if (!sub_flags.borrow)
               rem_in = sub_diff[W-1:0];
            else
               rem_in = div_shift[W-1:0];
            a_in   = {a_ff[W-2:0], !sub_flags.borrow};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_MUL: begin
            m_in = product;
         end
         ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   // Result formatting and output register
   always_comb begin
      res_in       = res_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         unique case (op_ff)
            OP_GCD: begin
               res_in = g_ff;
               ovf_in = 1'b0;
            end
            OP_LCM: begin
               res_in = m_ff[W-1:0];
               ovf_in = |m_ff[2*W-1:W];
            end
            OP_SLCM: begin
               if (neg_ff) begin
                  res_in = ~m_ff[W-1:0] + W'(1);
                  ovf_in = (|m_ff[2*W-1:W]) || (m_ff[W-1] && (|m_ff[W-2:0]));
               end else begin
                  res_in = m_ff[W-1:0];
                  ovf_in = |m_ff[2*W-1:W-1];
               end
            end
            default: begin
               res_in = '0;
               ovf_in = 1'b0;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      rem_ff  <= rem_in;
      twos_ff <= twos_in;
      cnt_ff  <= cnt_in;
      m_ff    <= m_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = FIELD_WIDTH'(res_ff);
   assign rsp_tuser  = ovf_ff;

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bgl_pkg::*;

   // Op code 3 has no enum member; the unit answers it with zero
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
   localparam int STUCK_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_REQUESTS = 1900;

   typedef struct {
      logic [OP_WIDTH-1:0] op;
      logic [31:0]         a;
      logic [31:0]         b;
      logic                drain;   // hold this request until all answers are back
   } request_item_type;

   typedef struct {
      logic [OP_WIDTH-1:0] op;
      logic [31:0]         a;
      logic [31:0]         b;
      logic [31:0]         result;
      logic                overflow;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [2*FIELD_WIDTH-1:0]        req_tdata = '0;   // operand_a, operand_b
   logic [OP_WIDTH-1:0]             req_tuser = '0;   // op
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [FIELD_WIDTH-1:0]          rsp_tdata;        // result
   logic                            rsp_tuser;        // overflow

   request_item_type request_queue[$];
   answer_type       pending_answers[$];

   int req_wait = 0;
   int rsp_wait = 0;
   int sent_count = 0;
   int received_count = 0;
   int error_count = 0;
   int stuck_cycles = 0;

   binary_gcd_lcm_unit_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Euclid on wide magnitudes; gcd(0,y) = y, gcd(x,0) = x
   function automatic logic [64:0] gcd_of(logic [64:0] x, logic [64:0] y);
      logic [64:0] rem;
      while (y != 0) begin
         rem = x % y;
         x = y;
         y = rem;
      end
      return x;
   endfunction

   // Exact lcm of magnitudes up to 2^32; zero when either is zero
   function automatic logic [64:0] lcm_of(logic [64:0] x, logic [64:0] y);
      if (x == 0 || y == 0)
         return '0;
      return (x / gcd_of(x, y)) * y;
   endfunction

   function automatic answer_type compute_answer(logic [OP_WIDTH-1:0] op,
                                                 logic [31:0] a, logic [31:0] b);
      answer_type  ans;
      logic [64:0] m;
      logic [64:0] neg_m;
      logic [64:0] a_mag;
      logic [64:0] b_mag;
      logic        a_neg;
      logic        b_neg;
      logic        neg;
      ans.op = op;
      ans.a = a;
      ans.b = b;
      ans.result = '0;
      ans.overflow = 1'b0;
      case (op)
         OP_GCD: begin
            m = gcd_of({33'd0, a}, {33'd0, b});
            ans.result = m[31:0];
         end
         OP_LCM: begin
            m = lcm_of({33'd0, a}, {33'd0, b});
            ans.result = m[31:0];
            ans.overflow = (m > 65'hFFFF_FFFF);
         end
         OP_SLCM: begin
            a_neg = a[31];
            b_neg = b[31];
            a_mag = a_neg ? (65'h1_0000_0000 - {33'd0, a}) : {33'd0, a};
            b_mag = b_neg ? (65'h1_0000_0000 - {33'd0, b}) : {33'd0, b};
            // a negative second operand flips both signs
            neg = b_neg ? (!a_neg && a != 0) : a_neg;
            m = lcm_of(a_mag, b_mag);
            if (m == 0) begin
               ans.result = '0;
            end else if (neg) begin
               neg_m = 65'd0 - m;
               ans.result = neg_m[31:0];
               ans.overflow = (m > 65'h8000_0000);
            end else begin
               ans.result = m[31:0];
               ans.overflow = (m > 65'h7FFF_FFFF);
            end
         end
         default: begin
            ans.result = '0;
         end
      endcase
      return ans;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_request(logic [OP_WIDTH-1:0] op, logic [31:0] a, logic [31:0] b,
                              logic drain);
      request_item_type item;
      item.op = op;
      item.a = a;
      item.b = b;
      item.drain = drain;
      request_queue.push_back(item);
   endtask

   function automatic logic [31:0] any_operand();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return $urandom_range(0, 255);
         3:       return $urandom_range(0, 65535);
         4:       return 32'd1 << $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // Runs of requests with no idling alternate with randomly idled ones
   function automatic int draw_wait(int n);
      if ((n / 128) % 3 == 0)
         return 0;
      return $urandom_range(0, 6);
   endfunction

   task automatic flag_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      request_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait <= 0;
      end else begin
         // predict as soon as the unit takes the request
         if (req_tvalid && req_tready)
            pending_answers.push_back(compute_answer(req_tuser, req_tdata[31:0],
                                                     req_tdata[63:32]));
         if (req_tvalid && !req_tready) begin
            // hold the current request
         end else if (req_wait != 0) begin
            req_tvalid <= 1'b0;
            req_wait <= req_wait - 1;
         end else if (request_queue.size() != 0 &&
                      !(request_queue[0].drain && pending_answers.size() != 0)) begin
            nxt = request_queue.pop_front();
            req_tdata <= {nxt.b, nxt.a};
            req_tuser <= nxt.op;
            req_tvalid <= 1'b1;
            req_wait <= draw_wait(sent_count);
            sent_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      answer_type want;
      int         stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            flag_mismatch($sformatf("result %h/%b with no request outstanding",
                                    rsp_tdata, rsp_tuser));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== want.result)
               flag_mismatch($sformatf("op %0d a %h b %h: result %h, expected %h",
                                       want.op, want.a, want.b, rsp_tdata, want.result));
            if (rsp_tuser !== want.overflow)
               flag_mismatch($sformatf("op %0d a %h b %h: overflow %b, expected %b",
                                       want.op, want.a, want.b, rsp_tuser, want.overflow));
         end
         stall = draw_wait(received_count);
         received_count++;
         rsp_wait <= stall;
         rsp_tready <= (stall == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: no handshake on either side for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: fill the request queue, reset, wait for the drain
   // ---------------------------------------------------------------------
   initial begin
      logic [OP_WIDTH-1:0] op;
      logic [31:0]         a;
      logic [31:0]         b;
      int                  pick;
      int                  common;

      // directed: zero operands, extremes, sign handling, unused op
      add_request(OP_GCD,  32'h0000_0000, 32'h0000_0000, 1'b0);
      add_request(OP_GCD,  32'h0000_0000, 32'h0000_0024, 1'b0);
      add_request(OP_GCD,  32'h8765_4321, 32'h0000_0000, 1'b0);
      add_request(OP_GCD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_request(OP_GCD,  32'h8000_0000, 32'hC000_0000, 1'b0);
      add_request(OP_GCD,  32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
      add_request(OP_GCD,  32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0);
      add_request(OP_LCM,  32'h0000_0000, 32'h0000_0000, 1'b0);
      add_request(OP_LCM,  32'h0000_0000, 32'h0000_0005, 1'b0);
      add_request(OP_LCM,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      add_request(OP_LCM,  32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
      add_request(OP_LCM,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_request(OP_LCM,  32'h0001_0000, 32'h0001_0000, 1'b0);
      add_request(OP_LCM,  32'h0001_0000, 32'h0000_FFFF, 1'b0);
      add_request(OP_SLCM, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_request(OP_SLCM, 32'h8000_0000, 32'h0000_0001, 1'b0);
      add_request(OP_SLCM, 32'h0000_0001, 32'h8000_0000, 1'b0);
      add_request(OP_SLCM, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      add_request(OP_SLCM, 32'hFFFF_FFFD, 32'h0000_0004, 1'b0);
      add_request(OP_SLCM, 32'h0000_0003, 32'hFFFF_FFFC, 1'b0);
      add_request(OP_SLCM, 32'hFFFF_FFFD, 32'hFFFF_FFFC, 1'b0);
      add_request(OP_SLCM, 32'h0000_0000, 32'hFFFF_FFFB, 1'b0);
      add_request(OP_SLCM, 32'hFFFF_FFFB, 32'h0000_0000, 1'b0);
      add_request(OP_SLCM, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0);
      add_request(OP_UNUSED, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);

      // random: shared factors keep many lcms in range; two drain points
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 32)
            op = OP_GCD;
         else if (pick < 64)
            op = OP_LCM;
         else if (pick < 96)
            op = OP_SLCM;
         else
            op = OP_UNUSED;
         if ($urandom_range(0, 9) < 4) begin
            common = $urandom_range(1, 4095);
            a = common * $urandom_range(0, 1023);
            b = common * $urandom_range(0, 1023);
         end else begin
            a = any_operand();
            b = any_operand();
         end
         if (op == OP_SLCM) begin
            if ($urandom_range(0, 1) == 1)
               a = 32'd0 - a;
            if ($urandom_range(0, 1) == 1)
               b = 32'd0 - b;
         end
         add_request(op, a, b, (i == 0 || i == RANDOM_REQUESTS / 2));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_tvalid || pending_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      // every request must have been answered by now
      if (pending_answers.size() != 0)
         flag_mismatch($sformatf("%0d requests never answered", pending_answers.size()));

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
